// File: rtl/core/sds_pkg.sv
// package with types and constants shared by the scan disk scheduler modules
`timescale 1ns / 1ps

package sds_pkg;

  localparam int MAX_REQUESTS  = 32;
  localparam int CYLINDER_BITS = 16;
  localparam int IDX_W         = $clog2(MAX_REQUESTS);
  localparam int CNT_W         = $clog2(MAX_REQUESTS + 1);
  localparam int TOTAL_W       = 22;

  typedef struct packed {
    logic [15:0] cylinder;
    logic        last_request;
  } req_t;

  typedef struct packed {
    logic [15:0]        target;
    logic [15:0]        distance;
    logic [TOTAL_W-1:0] running_total;
    logic               final_move;
    logic               dropped;
  } move_t;

  // commands from controller to datapath
  typedef struct packed {
    logic insert;
    logic sweep_init;
    logic idx_inc;
    logic idx_dec;
    logic save_split;
    logic idx_from_split;
    logic rd_prev;
    logic emit;
    logic emit_zero;
    logic final_move;
    logic batch_clear;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic find_more;
    logic idx_zero;
    logic split_is_count;
    logic up_last;
    logic slot_free;
  } dp_status_t;

endpackage

// File: rtl/core/sds_datapath.sv
// datapath: sorted request store, head and total registers, output register
`timescale 1ns / 1ps

module sds_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sds_pkg::ctrl_cmd_t  cmd,
  input  sds_pkg::req_t       req,
  input  logic                cfg_valid,
  input  logic [15:0]         cfg_data,
  input  logic                mv_stall,
  output logic                mv_valid,
  output sds_pkg::move_t      mv,
  output sds_pkg::dp_status_t st
);

  logic [sds_pkg::CYLINDER_BITS-1:0] store [sds_pkg::MAX_REQUESTS];
  logic [sds_pkg::CYLINDER_BITS-1:0] store_next [sds_pkg::MAX_REQUESTS];
  logic [sds_pkg::MAX_REQUESTS-1:0]  gt;
  logic [sds_pkg::CNT_W-1:0]         count;
  logic                              overflow;
  logic [sds_pkg::CNT_W-1:0]         idx;
  logic [sds_pkg::CNT_W-1:0]         split;
  logic [sds_pkg::CYLINDER_BITS-1:0] head;
  logic [sds_pkg::CYLINDER_BITS-1:0] start_cyl;
  logic [sds_pkg::TOTAL_W-1:0]       total;
  logic [sds_pkg::TOTAL_W-1:0]       total_next;
  logic [sds_pkg::CYLINDER_BITS-1:0] new_cyl;
  logic [sds_pkg::CNT_W-1:0]         rd_full;
  logic [sds_pkg::IDX_W-1:0]         rd_addr;
  logic [sds_pkg::CYLINDER_BITS-1:0] rd_data;
  logic [sds_pkg::CYLINDER_BITS-1:0] tgt;
  logic [sds_pkg::CYLINDER_BITS-1:0] step_dist;
  logic                              store_full;

  assign new_cyl    = req.cylinder[sds_pkg::CYLINDER_BITS-1:0];
  assign store_full = (count == sds_pkg::CNT_W'(sds_pkg::MAX_REQUESTS));

  // insertion cells: every entry above the insert point shifts up by one
  always_comb begin
    for (int i = 0; i < sds_pkg::MAX_REQUESTS; i++) begin
      gt[i] = (sds_pkg::CNT_W'(i) >= count) || (store[i] > new_cyl);
    end
    for (int i = 0; i < sds_pkg::MAX_REQUESTS; i++) begin
      if (!gt[i]) begin
        store_next[i] = store[i];
      end else if (i != 0 && gt[(i == 0) ? 0 : i - 1]) begin
        store_next[i] = store[(i == 0) ? 0 : i - 1];
      end else begin
        store_next[i] = new_cyl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && !store_full) begin
      for (int i = 0; i < sds_pkg::MAX_REQUESTS; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

  // read port for the sweep
  assign rd_full = cmd.rd_prev ? (idx - sds_pkg::CNT_W'(1)) : idx;
  assign rd_addr = rd_full[sds_pkg::IDX_W-1:0];
  assign rd_data = store[rd_addr];

  // move arithmetic
  assign tgt        = cmd.emit_zero ? '0 : rd_data;
  assign step_dist  = (tgt > head) ? (tgt - head) : (head - tgt);
  assign total_next = total + sds_pkg::TOTAL_W'(step_dist);

  // batch count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (cmd.batch_clear) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (cmd.insert) begin
      if (store_full) begin
        overflow <= 1'b1;
      end else begin
        count <= count + sds_pkg::CNT_W'(1);
      end
    end
  end

  // start position register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_cyl <= '0;
    end else if (cfg_valid) begin
      start_cyl <= cfg_data[sds_pkg::CYLINDER_BITS-1:0];
    end
  end

  // sweep pointer and split point
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      split <= '0;
    end else begin
      if (cmd.sweep_init) begin
        idx <= '0;
      end else if (cmd.idx_from_split) begin
        idx <= split;
      end else if (cmd.idx_inc) begin
        idx <= idx + sds_pkg::CNT_W'(1);
      end else if (cmd.idx_dec) begin
        idx <= idx - sds_pkg::CNT_W'(1);
      end
      if (cmd.save_split) begin
        split <= idx;
      end
    end
  end

  // head position and running total
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      total <= '0;
    end else if (cmd.sweep_init) begin
      head  <= start_cyl;
      total <= '0;
    end else if (cmd.emit) begin
      head  <= tgt;
      total <= total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mv_valid <= 1'b0;
    end else if (cmd.emit) begin
      mv_valid <= 1'b1;
    end else if (!mv_stall) begin
      mv_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mv.target        <= 16'(tgt);
      mv.distance      <= 16'(step_dist);
      mv.running_total <= total_next;
      mv.final_move    <= cmd.final_move;
      mv.dropped       <= overflow;
    end
  end

  // status to controller
  assign st.find_more      = (idx < count) && (rd_data <= head);
  assign st.idx_zero       = (idx == '0);
  assign st.split_is_count = (split == count);
  assign st.up_last        = ((idx + sds_pkg::CNT_W'(1)) == count);
  assign st.slot_free      = !mv_valid || !mv_stall;

endmodule

// File: rtl/core/sds_ctrl.sv
// controller: load, split search, downward pass, end stop, upward pass
`timescale 1ns / 1ps

module sds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                last_request,
  input  sds_pkg::dp_status_t st,
  output logic                req_stall,
  output sds_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_FIND = 3'd1;
  localparam logic [2:0] ST_DOWN = 3'd2;
  localparam logic [2:0] ST_ZERO = 3'd3;
  localparam logic [2:0] ST_UP   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != ST_LOAD);

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_LOAD: begin
        if (req_valid) begin
          cmd.insert = 1'b1;
          if (last_request) begin
            cmd.sweep_init = 1'b1;
            state_next     = ST_FIND;
          end
        end
      end
      ST_FIND: begin
        if (st.find_more) begin
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.save_split = 1'b1;
          state_next     = ST_DOWN;
        end
      end
      ST_DOWN: begin
        cmd.rd_prev = 1'b1;
        if (st.idx_zero) begin
          state_next = ST_ZERO;
        end else if (st.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.idx_dec = 1'b1;
        end
      end
      ST_ZERO: begin
        if (st.slot_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_zero  = 1'b1;
          cmd.final_move = st.split_is_count;
          if (st.split_is_count) begin
            cmd.batch_clear = 1'b1;
            state_next      = ST_LOAD;
          end else begin
            cmd.idx_from_split = 1'b1;
            state_next         = ST_UP;
          end
        end
      end
      ST_UP: begin
        if (st.slot_free) begin
          cmd.emit       = 1'b1;
          cmd.idx_inc    = 1'b1;
          cmd.final_move = st.up_last;
          if (st.up_last) begin
            cmd.batch_clear = 1'b1;
            state_next      = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/core/scan_disk_scheduler_core.sv
// scan disk scheduler top level: requests in, head moves out
// a request without the last mark is stored and gives no move
// the last request starts a split search over the s requests at or below the head,
// then n+1 moves leave down to the end stop at 0 and back up, held while the output stalls
// requests load at one per cycle in the load state and are stalled until the sweep ends
// reset (synchronous) empties the batch, clears the output and sets start to 0
`timescale 1ns / 1ps

module scan_disk_scheduler_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  sds_pkg::req_t   req,
  output logic            mv_valid,
  input  logic            mv_stall,
  output sds_pkg::move_t  mv,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data
);

  sds_pkg::ctrl_cmd_t  cmd;
  sds_pkg::dp_status_t st;

  // start register always takes a write
  assign cfg_ready = 1'b1;

  sds_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .last_request (req.last_request),
    .st           (st),
    .req_stall    (req_stall),
    .cmd          (cmd)
  );

  sds_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .mv_stall  (mv_stall),
    .mv_valid  (mv_valid),
    .mv        (mv),
    .st        (st)
  );

endmodule

// File: rtl/core/sds_checker.sv
// port-level checker for the scan disk scheduler, bound to the top level
`timescale 1ns / 1ps

module sds_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input sds_pkg::req_t  req,
  input logic           mv_valid,
  input logic           mv_stall,
  input sds_pkg::move_t mv
);

  // a stalled move transaction holds
  a_mv_hold: assert property (@(posedge clk) disable iff (rst)
    mv_valid && mv_stall |=> mv_valid && $stable(mv))
    else $error("stalled move changed");

  // no move right after reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !mv_valid)
    else $error("move valid after reset");

  // sweep still running while a non-final move waits
  a_sweep_busy: assert property (@(posedge clk) disable iff (rst)
    mv_valid && !mv.final_move |-> req_stall)
    else $error("request taken during sweep");

  // loading a request that is not last creates no move
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && !req.last_request && !mv_valid |=> !mv_valid)
    else $error("move during batch loading");

  // running total covers this move
  a_total: assert property (@(posedge clk) disable iff (rst)
    mv_valid |-> mv.running_total >= sds_pkg::TOTAL_W'(mv.distance))
    else $error("running total below distance");

endmodule

bind scan_disk_scheduler_core sds_checker u_sds_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .mv_valid  (mv_valid),
  .mv_stall  (mv_stall),
  .mv        (mv)
);

// File: test/scan_disk_scheduler_core_tb.sv
// self-checking testbench for the scan disk scheduler: directed and random batches
`timescale 1ns / 1ps

module scan_disk_scheduler_core_tb;

  localparam int NUM_ITEMS   = 410;
  localparam int IDLE_OFF_AT = 350;
  localparam int SETTLE      = 8;

  // predicts the moves of each sweep and checks the moves that come out
  class sweep_board;
    sds_pkg::move_t              pending_moves[$];
    logic [15:0]                 held[sds_pkg::MAX_REQUESTS];
    int                          held_count;
    bit                          overflow;
    logic [15:0]                 start_pos;
    logic [15:0]                 sweep_head;
    logic [sds_pkg::TOTAL_W-1:0] sweep_total;
    int                          mismatches;

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    function void add_move(logic [15:0] tgt);
      sds_pkg::move_t m;
      logic [15:0]    step_dist;
      step_dist = (tgt > sweep_head) ? tgt - sweep_head : sweep_head - tgt;
      sweep_total = sweep_total + sds_pkg::TOTAL_W'(step_dist);
      sweep_head = tgt;
      m.target = tgt;
      m.distance = step_dist;
      m.running_total = sweep_total;
      m.final_move = 1'b0;
      m.dropped = overflow;
      pending_moves.push_back(m);
    endfunction

    // one accepted request transaction: store it, and on the last one plan the sweep
    function void note_request(sds_pkg::req_t r);
      logic [15:0] sorted[sds_pkg::MAX_REQUESTS];
      logic [15:0] v;
      logic [15:0] mask;
      int          i;
      int          j;
      int          split;
      mask = 16'((32'd1 << sds_pkg::CYLINDER_BITS) - 1);
      if (held_count < sds_pkg::MAX_REQUESTS) begin
        held[held_count] = r.cylinder & mask;
        held_count++;
      end else begin
        overflow = 1'b1;
      end
      if (!r.last_request) return;

      // ascending order of the held batch
      for (i = 0; i < held_count; i++) sorted[i] = held[i];
      for (i = 1; i < held_count; i++) begin
        v = sorted[i];
        j = i - 1;
        while (j >= 0 && sorted[j] > v) begin
          sorted[j + 1] = sorted[j];
          j--;
        end
        sorted[j + 1] = v;
      end

      // down through requests at or below the head, end stop, then up
      sweep_head = start_pos & mask;
      sweep_total = '0;
      split = 0;
      while (split < held_count && sorted[split] <= sweep_head) split++;
      for (i = split - 1; i >= 0; i--) add_move(sorted[i]);
      add_move(16'd0);
      for (i = split; i < held_count; i++) add_move(sorted[i]);
      pending_moves[pending_moves.size() - 1].final_move = 1'b1;

      held_count = 0;
      overflow = 1'b0;
    endfunction

    task check_move(sds_pkg::move_t got);
      sds_pkg::move_t want;
      if (pending_moves.size() == 0) begin
        report_mismatch($sformatf("move to %0d with none expected", got.target));
        return;
      end
      want = pending_moves.pop_front();
      if (got.target !== want.target)
        report_mismatch($sformatf("target %0d, want %0d", got.target, want.target));
      if (got.distance !== want.distance)
        report_mismatch($sformatf("distance %0d, want %0d", got.distance, want.distance));
      if (got.running_total !== want.running_total)
        report_mismatch($sformatf("running_total %0d, want %0d",
                                  got.running_total, want.running_total));
      if (got.final_move !== want.final_move)
        report_mismatch($sformatf("final_move %0b, want %0b", got.final_move, want.final_move));
      if (got.dropped !== want.dropped)
        report_mismatch($sformatf("dropped %0b, want %0b", got.dropped, want.dropped));
    endtask
  endclass

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  sds_pkg::req_t  req;
  logic           mv_valid;
  logic           mv_stall;
  sds_pkg::move_t mv;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [15:0]    cfg_data;

  sweep_board board = new;
  bit         idle_en = 1'b1;
  bit         calm_batch = 1'b0;
  int         items_sent = 0;

  scan_disk_scheduler_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .mv_valid  (mv_valid),
    .mv_stall  (mv_stall),
    .mv        (mv),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // move transaction monitor
  always @(posedge clk) begin
    if (!rst && mv_valid && !mv_stall) board.check_move(mv);
  end

  // output stall bursts, off in the last part of the run
  initial begin
    mv_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 80 : 12)) @(posedge clk);
      if (idle_en && $urandom_range(0, 2) == 0) begin
        mv_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        mv_stall <= 1'b0;
      end
    end
  end

  // one request transaction, with an optional gap before it
  task send_request(input logic [15:0] cyl, input bit last);
    sds_pkg::req_t r;
    int            gap;
    r.cylinder = cyl;
    r.last_request = last;
    gap = (idle_en && !calm_batch && $urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    board.note_request(r);
    items_sent++;
  endtask

  // drain all moves, let the block settle, then write the start cylinder
  task write_start(input logic [15:0] value);
    req_valid <= 1'b0;
    while (board.pending_moves.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.start_pos = value;
  endtask

  function automatic logic [15:0] pick_cylinder();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return board.start_pos;
      3:       return board.start_pos + 16'($urandom_range(0, 6)) - 16'd3;
      4:       return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_start();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 31));
      default: return 16'($urandom);
    endcase
  endfunction

  // batch sizes: mostly short, some at and past a full store
  function automatic int pick_batch_len();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) == 0) ? 32 + $urandom_range(0, 2)
                                                  : $urandom_range(35, 40);
      1:       return 1;
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  task run_batch(input int len);
    int i;
    calm_batch = ($urandom_range(0, 3) == 0);
    for (i = 0; i < len; i++) send_request(pick_cylinder(), i == len - 1);
  endtask

  // stimulus
  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // lone request at cylinder 0 from the reset start: nothing above the head
    send_request(16'd0, 1'b1);

    // head at the top end: everything lies below, one request equals the head
    write_start(16'hFFFF);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'd1234, 1'b1);

    // mixed batch around the head, both neighbors and both extremes
    write_start(16'd1000);
    send_request(16'd500, 1'b0);
    send_request(16'd1500, 1'b0);
    send_request(16'd1000, 1'b0);
    send_request(16'd0, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'd999, 1'b0);
    send_request(16'd1001, 1'b1);

    // head at 0: the end stop comes first, then the rising pass with duplicates
    write_start(16'd0);
    send_request(16'd5, 1'b0);
    send_request(16'd3, 1'b0);
    send_request(16'd3, 1'b0);
    send_request(16'hFFFF, 1'b1);

    // head in the middle of the range
    write_start(16'h8000);
    send_request(16'h7FFF, 1'b0);
    send_request(16'h8001, 1'b1);

    // random batches, start cylinder changed between some of them
    while (items_sent < NUM_ITEMS) begin
      if (items_sent >= IDLE_OFF_AT) idle_en = 1'b0;
      if ($urandom_range(0, 2) == 0) write_start(pick_start());
      run_batch(pick_batch_len());
    end
    req_valid <= 1'b0;

    // drain and settle
    while (board.pending_moves.size() != 0) @(posedge clk);
    repeat (2 * sds_pkg::MAX_REQUESTS + 10) @(posedge clk);

    if (board.mismatches == 0 && board.pending_moves.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/sds_pkg.sv
rtl/core/sds_datapath.sv
rtl/core/sds_ctrl.sv
rtl/core/scan_disk_scheduler_core.sv
rtl/core/sds_checker.sv
test/scan_disk_scheduler_core_tb.sv
